@@ hdl/ths_pkg.sv @@
`default_nettype none

package ths_pkg;

    localparam int TIME_W     = 32;
    localparam int CMD_W      = 2;
    localparam int TIDX_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int SLOTS      = 4;
    localparam int SLOT_W     = 2;
    localparam int TASK_COUNT = 4;

    localparam logic [CMD_W-1:0] CMD_REPORT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CHECK     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ_TIME = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ_MISS = 2'd3;

    localparam logic [TIME_W-1:0] DEADLINE_RESET [SLOTS] = '{
        32'd2500, 32'd1500, 32'd500, 32'd1500
    };

    typedef struct packed {
        logic load;
        logic rw;
        logic walk;
        logic finish;
    } ctrl_t;

    typedef struct packed {
        logic started;
        logic late;
        logic last;
    } stat_t;

endpackage

`default_nettype wire

@@ hdl/ths_ctrl.sv @@
`default_nettype none

module ths_ctrl
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [ths_pkg::CMD_W-1:0] command,
    input  wire ths_pkg::stat_t            stat,
    output ths_pkg::ctrl_t                 ctrl,
    output logic                           busy
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RW   = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        ctrl       = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = (command == ths_pkg::CMD_CHECK) ? ST_WALK : ST_RW;
                end
            end
            ST_RW:
            begin
                ctrl.rw    = 1'b1;
                state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                ctrl.walk = 1'b1;
                if (!stat.started || stat.late || stat.last)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

@@ hdl/ths_dpath.sv @@
`default_nettype none

module ths_dpath
#(
    parameter int TASK_COUNT = ths_pkg::TASK_COUNT
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ths_pkg::ctrl_t                ctrl,
    output ths_pkg::stat_t                     stat,
    input  wire logic [ths_pkg::CMD_W-1:0]     command,
    input  wire logic [ths_pkg::TIDX_W-1:0]    task_index,
    input  wire logic [ths_pkg::TIME_W-1:0]    current_time,
    input  wire logic                          cfg_we,
    input  wire logic [ths_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ths_pkg::TIME_W-1:0]    cfg_data,
    output logic                               done,
    output logic                               healthy,
    output logic [ths_pkg::TIME_W-1:0]         read_value
);

    localparam int IW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
    localparam logic [IW-1:0] LAST_CNT = IW'(TASK_COUNT - 1);
    localparam logic [ths_pkg::TIDX_W-1:0] TASK_LIMIT = ths_pkg::TIDX_W'(TASK_COUNT);

    logic [ths_pkg::TIME_W-1:0] deadline_reg  [ths_pkg::SLOTS];
    logic [ths_pkg::TIME_W-1:0] last_time_reg [TASK_COUNT];
    logic [ths_pkg::TIME_W-1:0] missed_reg    [TASK_COUNT];
    logic [TASK_COUNT-1:0]      started_reg;

    logic [ths_pkg::CMD_W-1:0]  cmd_reg;
    logic [ths_pkg::TIDX_W-1:0] idx_reg;
    logic [ths_pkg::TIME_W-1:0] now_reg;
    logic [IW-1:0]              cnt_reg;

    logic                       done_reg;
    logic                       healthy_reg;
    logic [ths_pkg::TIME_W-1:0] value_reg;

    logic                       idx_ok;
    logic [IW-1:0]              addr;
    logic [ths_pkg::TIME_W-1:0] sel_time;
    logic [ths_pkg::TIME_W-1:0] sel_missed;
    logic [ths_pkg::TIME_W-1:0] sel_deadline;
    logic [ths_pkg::TIME_W-1:0] elapsed;
    logic [ths_pkg::TIME_W-1:0] rd_data;

    assign idx_ok       = (idx_reg < TASK_LIMIT);
    assign addr         = ctrl.walk ? cnt_reg : idx_reg[IW-1:0];
    assign sel_time     = last_time_reg[addr];
    assign sel_missed   = missed_reg[addr];
    assign sel_deadline = deadline_reg[ths_pkg::SLOT_W'(addr)];
    assign elapsed      = now_reg - sel_time;

    assign stat.started = started_reg[addr];
    assign stat.late    = (elapsed > sel_deadline);
    assign stat.last    = (cnt_reg == LAST_CNT);

    always_comb
    begin
        rd_data = '0;
        unique case (cmd_reg)
            ths_pkg::CMD_READ_TIME: rd_data = idx_ok ? sel_time : '0;
            ths_pkg::CMD_READ_MISS: rd_data = idx_ok ? sel_missed : '0;
            ths_pkg::CMD_REPORT,
            ths_pkg::CMD_CHECK:     rd_data = '0;
            default:                rd_data = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= command;
            idx_reg <= task_index;
            now_reg <= current_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ths_pkg::SLOTS; i++)
            begin
                deadline_reg[i] <= ths_pkg::DEADLINE_RESET[i];
            end
        end
        else if (cfg_we && (cfg_index < ths_pkg::CFG_IDX_W'(ths_pkg::SLOTS)))
        begin
            deadline_reg[cfg_index[ths_pkg::SLOT_W-1:0]] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TASK_COUNT; i++)
            begin
                last_time_reg[i] <= '0;
                missed_reg[i]    <= '0;
            end
            started_reg <= '0;
            cnt_reg     <= '0;
            done_reg    <= 1'b0;
            healthy_reg <= 1'b0;
            value_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.load)
            begin
                cnt_reg <= '0;
            end
            if (ctrl.rw)
            begin
                if ((cmd_reg == ths_pkg::CMD_REPORT) && idx_ok)
                begin
                    last_time_reg[addr] <= now_reg;
                    started_reg[addr]   <= 1'b1;
                end
                done_reg    <= 1'b1;
                healthy_reg <= 1'b0;
                value_reg   <= rd_data;
            end
            if (ctrl.walk)
            begin
                if (stat.started && stat.late)
                begin
                    missed_reg[addr] <= sel_missed + 1'b1;
                end
                if (ctrl.finish)
                begin
                    done_reg    <= 1'b1;
                    healthy_reg <= stat.started && !stat.late;
                    value_reg   <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign done       = done_reg;
    assign healthy    = healthy_reg;
    assign read_value = value_reg;

endmodule

`default_nettype wire

@@ hdl/task_heartbeat_supervisor.sv @@
// Channel  | Handshake              | Signals
// ---------+------------------------+-----------------------------------------
// item in  | start & !busy          | command, task_index, current_time
// result   | done (one-cycle pulse) | healthy, read_value
// config   | cfg_valid & cfg_ready  | cfg_index, cfg_data
//
// Report and read commands: the item passes through the RW state, and
// done is registered at the end of it.
// Health check: one walk cycle per task visited; the walk ends at the first
// task not yet started or late, or at the last task, and done is registered as it ends.
// A new item is taken at the edge that ends the cycle done shows.
// rst_n clears all task state and loads the deadline defaults.
// The receiver cannot stall; cfg_ready is always high.
`default_nettype none

module task_heartbeat_supervisor
#(
    parameter int TASK_COUNT = ths_pkg::TASK_COUNT
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [ths_pkg::CMD_W-1:0]     command,
    input  wire logic [ths_pkg::TIDX_W-1:0]    task_index,
    input  wire logic [ths_pkg::TIME_W-1:0]    current_time,
    output logic                               done,
    output logic                               healthy,
    output logic [ths_pkg::TIME_W-1:0]         read_value,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ths_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ths_pkg::TIME_W-1:0]    cfg_data
);

    ths_pkg::ctrl_t ctrl;
    ths_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    ths_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .ctrl    (ctrl),
        .busy    (busy)
    );

    ths_dpath
    #(
        .TASK_COUNT (TASK_COUNT)
    )
    u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .command      (command),
        .task_index   (task_index),
        .current_time (current_time),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .healthy      (healthy),
        .read_value   (read_value)
    );

endmodule

`default_nettype wire

@@ hdl/ths_checker.sv @@
`default_nettype none

module ths_checker
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic                      done,
    input wire logic                      healthy,
    input wire logic [ths_pkg::TIME_W-1:0] read_value
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted item");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result strobe outside the end of an item");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done && healthy |-> read_value == '0)
        else $error("healthy verdict with nonzero read data");

endmodule

bind task_heartbeat_supervisor ths_checker u_ths_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .healthy    (healthy),
    .read_value (read_value)
);

`default_nettype wire

@@ dv/task_heartbeat_supervisor_tb.sv @@
`default_nettype none

module task_heartbeat_supervisor_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ths_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 175;
    localparam int SCRIPT_LEN  = 24;
    localparam int MAX_REPORTS = 60;

    typedef struct packed {
        logic              healthy;
        logic [TIME_W-1:0] value;
    } verdict_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [TIDX_W-1:0] idx;
        logic [TIME_W-1:0] stamp;
        logic              typed;
        logic              healthy;
        logic [TIME_W-1:0] value;
    } script_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [CMD_W-1:0]     command = CMD_REPORT;
    logic [TIDX_W-1:0]    task_index = '0;
    logic [TIME_W-1:0]    current_time = '0;
    logic                 done;
    logic                 healthy;
    logic [TIME_W-1:0]    read_value;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TIME_W-1:0]    cfg_data = '0;

    // expectation attached to the item on the ports
    logic                 item_typed = 1'b0;
    logic                 item_healthy = 1'b0;
    logic [TIME_W-1:0]    item_value = '0;

    logic [TIME_W-1:0]    deadline [SLOTS];
    logic [TIME_W-1:0]    last_seen [SLOTS];
    logic [TIME_W-1:0]    misses [SLOTS];
    logic                 started [SLOTS];

    verdict_t             awaited_results [$];
    int                   errors = 0;
    int                   gap_pct = 0;
    int                   stall_cycles = 0;

    const script_row_t opening_script [SCRIPT_LEN] = '{
        '{CMD_READ_TIME, 3'd0, 32'd0,          1'b1, 1'b0, 32'd0},
        '{CMD_READ_MISS, 3'd3, 32'd0,          1'b1, 1'b0, 32'd0},
        '{CMD_CHECK,     3'd0, 32'd0,          1'b1, 1'b0, 32'd0},
        '{CMD_REPORT,    3'd0, 32'd100,        1'b1, 1'b0, 32'd0},
        '{CMD_REPORT,    3'd7, 32'hFFFF_FFFF,  1'b1, 1'b0, 32'd0},
        '{CMD_READ_TIME, 3'd7, 32'd0,          1'b1, 1'b0, 32'd0},
        '{CMD_READ_TIME, 3'd0, 32'd0,          1'b1, 1'b0, 32'd100},
        '{CMD_REPORT,    3'd1, 32'd200,        1'b1, 1'b0, 32'd0},
        '{CMD_REPORT,    3'd2, 32'd300,        1'b1, 1'b0, 32'd0},
        '{CMD_REPORT,    3'd3, 32'hFFFF_FFFF,  1'b1, 1'b0, 32'd0},
        '{CMD_CHECK,     3'd0, 32'd800,        1'b1, 1'b1, 32'd0},
        '{CMD_CHECK,     3'd3, 32'd801,        1'b1, 1'b0, 32'd0},
        '{CMD_READ_MISS, 3'd2, 32'd0,          1'b1, 1'b0, 32'd1},
        '{CMD_READ_TIME, 3'd3, 32'd0,          1'b1, 1'b0, 32'hFFFF_FFFF},
        '{CMD_REPORT,    3'd4, 32'd12345,      1'b1, 1'b0, 32'd0},
        '{CMD_READ_TIME, 3'd4, 32'd0,          1'b1, 1'b0, 32'd0},
        '{CMD_READ_MISS, 3'd5, 32'd0,          1'b1, 1'b0, 32'd0},
        '{CMD_READ_MISS, 3'd6, 32'd0,          1'b1, 1'b0, 32'd0},
        '{CMD_REPORT,    3'd2, 32'd801,        1'b0, 1'b0, 32'd0},
        '{CMD_CHECK,     3'd0, 32'd0,          1'b0, 1'b0, 32'd0},
        '{CMD_READ_MISS, 3'd0, 32'd0,          1'b0, 1'b0, 32'd0},
        '{CMD_READ_MISS, 3'd2, 32'd0,          1'b0, 1'b0, 32'd0},
        '{CMD_CHECK,     3'd1, 32'd1100,       1'b0, 1'b0, 32'd0},
        '{CMD_READ_TIME, 3'd1, 32'd0,          1'b0, 1'b0, 32'd0}
    };

    task_heartbeat_supervisor uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .task_index   (task_index),
        .current_time (current_time),
        .done         (done),
        .healthy      (healthy),
        .read_value   (read_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic verdict_t apply_command(input logic [CMD_W-1:0] cmd,
                                               input logic [TIDX_W-1:0] idx,
                                               input logic [TIME_W-1:0] now);
        verdict_t          r;
        logic              ok;
        logic [TIME_W-1:0] gap;
        int                k;
        r = '0;
        ok = (idx < TASK_COUNT);
        case (cmd)
            CMD_REPORT:
                if (ok)
                begin
                    last_seen[idx[SLOT_W-1:0]] = now;
                    started[idx[SLOT_W-1:0]] = 1'b1;
                end
            CMD_CHECK:
            begin
                r.healthy = 1'b1;
                for (k = 0; k < TASK_COUNT; k++)
                begin
                    if (r.healthy)
                    begin
                        gap = now - last_seen[k];
                        if (!started[k])
                            r.healthy = 1'b0;
                        else if (gap > deadline[k])
                        begin
                            misses[k] = misses[k] + 32'd1;
                            r.healthy = 1'b0;
                        end
                    end
                end
            end
            CMD_READ_TIME:
                if (ok)
                    r.value = last_seen[idx[SLOT_W-1:0]];
            default:
                if (ok)
                    r.value = misses[idx[SLOT_W-1:0]];
        endcase
        return r;
    endfunction

    // predict on every accepted item, compare every result
    always @(posedge clk)
    begin : scoreboard
        verdict_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result healthy=%0b read_value=%h",
                             $time, healthy, read_value);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (healthy !== want.healthy)
                    begin
                        errors++;
                        $display("%0t: healthy expected %0b actual %0b",
                                 $time, want.healthy, healthy);
                    end
                    if (read_value !== want.value)
                    begin
                        errors++;
                        $display("%0t: read_value expected %h actual %h",
                                 $time, want.value, read_value);
                    end
                end
            end
            if (start && !busy)
            begin
                want = apply_command(command, task_index, current_time);
                if (item_typed)
                    want = {item_healthy, item_value};
                awaited_results.push_back(want);
            end
            if (cfg_valid && cfg_ready && cfg_index < SLOTS)
                deadline[cfg_index[SLOT_W-1:0]] = cfg_data;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TIDX_W-1:0] idx,
                             input logic [TIME_W-1:0] stamp, input logic typed,
                             input logic want_healthy, input logic [TIME_W-1:0] want_value);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        task_index <= idx;
        current_time <= stamp;
        item_typed <= typed;
        item_healthy <= want_healthy;
        item_value <= want_value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // hold off until every outstanding result has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_deadlines(input logic [SLOTS-1:0][TIME_W-1:0] d);
        int k;
        for (k = 0; k <= SLOTS; k++)
        begin
            cfg_valid <= 1'b1;
            if (k < SLOTS)
            begin
                cfg_index <= CFG_IDX_W'(k);
                cfg_data <= d[k];
            end
            else
            begin
                // out-of-range index: must leave every deadline alone
                cfg_index <= CFG_IDX_W'($urandom_range(SLOTS, 7));
                cfg_data <= $urandom;
            end
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [SLOTS-1:0][TIME_W-1:0] d;
        logic [CMD_W-1:0]             cmd;
        logic [TIDX_W-1:0]            idx;
        logic [TIME_W-1:0]            tick;
        logic [TIME_W-1:0]            stamp;
        int                           k;
        int                           p;
        int                           n;
        int                           pick;
        int                           step_max;
        for (k = 0; k < SLOTS; k++)
        begin
            deadline[k] = DEADLINE_RESET[k];
            last_seen[k] = '0;
            misses[k] = '0;
            started[k] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct = 32;
        for (k = 0; k < SCRIPT_LEN; k++)
            send_item(opening_script[k].cmd, opening_script[k].idx,
                      opening_script[k].stamp, opening_script[k].typed,
                      opening_script[k].healthy, opening_script[k].value);

        tick = 32'd2000;
        for (p = 0; p < PHASES; p++)
        begin
            drain();
            step_max = 300;
            case (p)
                0: d = {32'd1500, 32'd500, 32'd1500, 32'd2500};
                1:
                begin
                    d = '0;
                    step_max = 2;
                end
                2:
                begin
                    d = '1;
                    tick = 32'hFFFF_FC00;
                    step_max = 400;
                end
                3:
                    for (k = 0; k < SLOTS; k++)
                        d[k] = $urandom_range(0, 1000);
                4: d = {32'd700, $urandom, 32'd1, 32'h8000_0000};
                default:
                begin
                    d = {DEADLINE_RESET[3], DEADLINE_RESET[2],
                         DEADLINE_RESET[1], DEADLINE_RESET[0]};
                    tick = $urandom;
                    step_max = 250;
                end
            endcase
            if (p != 0)
                set_deadlines(d);
            gap_pct = (p < 2) ? 32 : (p < 4) ? 76 : 0;

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(99) == 0)
                    drain();
                pick = $urandom_range(99);
                cmd = (pick < 40) ? CMD_REPORT :
                      (pick < 70) ? CMD_CHECK :
                      (pick < 85) ? CMD_READ_TIME : CMD_READ_MISS;
                if ($urandom_range(9) == 0)
                    idx = TIDX_W'($urandom_range(SLOTS, 7));
                else
                    idx = TIDX_W'($urandom_range(0, SLOTS - 1));
                if ($urandom_range(99) < 12)
                    stamp = $urandom;
                else
                begin
                    tick = tick + TIME_W'($urandom_range(0, step_max));
                    stamp = tick;
                end
                send_item(cmd, idx, stamp, 1'b0, 1'b0, '0);
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (errors == 0 && awaited_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
